// ----- hw/rtl/vsa_pkg.sv -----
// Shared types and constants for the voice steal allocator.
// Holds the command codes and the item and result structs.
// No dependencies.
package vsa_pkg;

  // Field widths of the item and result
  localparam int POS_W   = 16;
  localparam int CMD_W   = 2;
  localparam int RV_W    = 4;
  localparam int VIDX_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PLAY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LISTENER = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    is_relative;
    logic [RV_W-1:0]         release_voice;
  } item_t;

  typedef struct packed {
    logic              granted;
    logic [VIDX_W-1:0] voice_index;
    logic              was_stolen;
  } result_t;

endpackage

// ----- hw/rtl/voice_steal_allocator.sv -----
// Voice allocator with distance-based stealing, top level.
// Keeps voice positions in a one-port synchronous memory and scans it on steal.
// Depends on vsa_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_stall    | item_t: cmd, position, flag, voice
//  result   | result_valid / result_stall| result_t: granted, index, stolen
//
// Release and listener items are taken in the idle step. A play request with an
// idle voice passes accept, priority pick and write back. With every voice busy
// the voice memory is read once per voice, and one more slot carries the new
// sound, through a four-stage distance pipeline. Reset clears busy flags,
// listener position and control; voice memory holds garbage until a play writes
// it. A stalled result blocks only the next play result; the item side stays open
// while the block is idle.
module voice_steal_allocator
  import vsa_pkg::*;
#(
  parameter int NUM_VOICES = 16,
  parameter int COORD_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CW    = COORD_BITS;
  localparam int RAW_W = (CW > POS_W) ? CW : POS_W;
  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W = $clog2(NUM_VOICES + 1);
  localparam int SQ_W  = 2 * CW + 1;
  localparam int DW    = SQ_W + 2;
  localparam int MEM_W = 1 + 3 * CW;
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(NUM_VOICES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;

  // Busy flags and listener position
  logic [NUM_VOICES-1:0] busy;
  logic signed [CW-1:0]  lx, ly, lz;

  // Captured request
  logic signed [CW-1:0]  req_x, req_y, req_z;
  logic                  req_rel;

  // Pending result
  logic                  res_grant;
  logic [VW-1:0]         res_idx;
  logic                  res_stolen;

  // Voice memory: {rel, x, y, z}
  logic [MEM_W-1:0]      mem [NUM_VOICES];
  logic [MEM_W-1:0]      rd_data;
  logic                  rd_en;

  // Scan control and pipeline
  logic [CNT_W-1:0]      issue_cnt;
  logic                  issue_end;
  logic                  rd_vld;
  logic [CNT_W-1:0]      rd_idx;
  logic                  d_vld;
  logic [CNT_W-1:0]      d_idx;
  logic                  d_rel;
  logic signed [CW:0]    d_x, d_y, d_z;
  logic                  m_vld;
  logic [CNT_W-1:0]      m_idx;
  logic                  m_rel;
  logic [SQ_W-1:0]       m_x, m_y, m_z;
  logic                  s_vld;
  logic [CNT_W-1:0]      s_idx;
  logic                  s_rel;
  logic [DW-1:0]         s_sum;
  logic [DW-1:0]         best;
  logic [VW-1:0]         sel;
  logic                  sel_rel;

  // Input coordinates, read as signed CW-bit values
  logic [RAW_W-1:0]      raw_x, raw_y, raw_z;
  logic signed [CW-1:0]  in_x, in_y, in_z;

  assign raw_x = RAW_W'($unsigned(item.pos_x));
  assign raw_y = RAW_W'($unsigned(item.pos_y));
  assign raw_z = RAW_W'($unsigned(item.pos_z));
  assign in_x  = signed'(raw_x[CW-1:0]);
  assign in_y  = signed'(raw_y[CW-1:0]);
  assign in_z  = signed'(raw_z[CW-1:0]);

  logic item_take;
  logic out_free;
  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Lowest idle voice
  logic          free_any;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_any = ~&busy;
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!busy[i]) free_idx = VW'(i);
    end
  end

  // Distance pipeline source: memory entry or the new sound
  logic                 src_req;
  logic signed [CW-1:0] src_x, src_y, src_z;
  logic                 src_rel;
  always_comb begin
    src_req = (rd_idx == LAST_SLOT);
    src_rel = src_req ? req_rel : rd_data[MEM_W-1];
    src_x   = src_req ? req_x : signed'(rd_data[3*CW-1:2*CW]);
    src_y   = src_req ? req_y : signed'(rd_data[2*CW-1:CW]);
    src_z   = src_req ? req_z : signed'(rd_data[CW-1:0]);
  end

  logic signed [2*CW+1:0] sq_x, sq_y, sq_z;
  assign sq_x = (2*CW+2)'(d_x) * (2*CW+2)'(d_x);
  assign sq_y = (2*CW+2)'(d_y) * (2*CW+2)'(d_y);
  assign sq_z = (2*CW+2)'(d_z) * (2*CW+2)'(d_z);

  // Voice memory: registered read, single write
  assign rd_en = (state == ST_SCAN) && !issue_end && (issue_cnt < LAST_SLOT);
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[issue_cnt[VW-1:0]];
    end
    if (state == ST_EMIT && out_free && res_grant) begin
      mem[res_idx] <= {req_rel, req_x, req_y, req_z};
    end
  end

  // Distance pipeline datapath
  always_ff @(posedge clk) begin
    d_idx <= rd_idx;
    d_rel <= src_rel;
    d_x   <= (CW+1)'(src_x) - (CW+1)'(lx);
    d_y   <= (CW+1)'(src_y) - (CW+1)'(ly);
    d_z   <= (CW+1)'(src_z) - (CW+1)'(lz);
    m_idx <= d_idx;
    m_rel <= d_rel;
    m_x   <= sq_x[SQ_W-1:0];
    m_y   <= sq_y[SQ_W-1:0];
    m_z   <= sq_z[SQ_W-1:0];
    s_idx <= m_idx;
    s_rel <= m_rel;
    s_sum <= DW'(m_x) + DW'(m_y) + DW'(m_z);
  end

  // Sequencer, busy flags, listener and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= '0;
      lx           <= '0;
      ly           <= '0;
      lz           <= '0;
      issue_cnt    <= '0;
      issue_end    <= 1'b1;
      rd_vld       <= 1'b0;
      d_vld        <= 1'b0;
      m_vld        <= 1'b0;
      s_vld        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      d_vld <= rd_vld;
      m_vld <= d_vld;
      s_vld <= m_vld;

      // Drop a delivered result unless the emit step loads the next one
      if (result_valid && !result_stall && state != ST_EMIT) result_valid <= 1'b0;

      // Issue one memory slot per cycle while scanning
      rd_vld <= (state == ST_SCAN) && !issue_end;
      if (state == ST_SCAN && !issue_end) begin
        rd_idx <= issue_cnt;
        if (issue_cnt == LAST_SLOT) issue_end <= 1'b1;
        else issue_cnt <= issue_cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (item_take) begin
            req_x   <= in_x;
            req_y   <= in_y;
            req_z   <= in_z;
            req_rel <= item.is_relative;
            case (item.cmd)
              CMD_PLAY: state <= ST_ALLOC;
              CMD_RELEASE: begin
                if (int'(item.release_voice) < NUM_VOICES) begin
                  busy[VW'(item.release_voice)] <= 1'b0;
                end
              end
              CMD_LISTENER: begin
                lx <= in_x;
                ly <= in_y;
                lz <= in_z;
              end
              default: ;
            endcase
          end
        end
        ST_ALLOC: begin
          res_idx    <= free_idx;
          res_grant  <= free_any;
          res_stolen <= 1'b0;
          if (free_any) begin
            state <= ST_EMIT;
          end else begin
            issue_cnt <= '0;
            issue_end <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Track the farthest voice, then weigh it against the new sound
          if (s_vld) begin
            if (s_idx == '0) begin
              best    <= s_sum;
              sel     <= '0;
              sel_rel <= s_rel;
            end else if (s_idx != LAST_SLOT) begin
              if (s_sum > best && !s_rel) begin
                best    <= s_sum;
                sel     <= s_idx[VW-1:0];
                sel_rel <= 1'b0;
              end
            end else begin
              res_grant  <= (best > s_sum) && !sel_rel;
              res_stolen <= (best > s_sum) && !sel_rel;
              res_idx    <= ((best > s_sum) && !sel_rel) ? sel : '0;
              state      <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            result.granted     <= res_grant;
            result.voice_index <= res_grant ? VIDX_W'(res_idx) : '0;
            result.was_stolen  <= res_stolen;
            if (res_grant) busy[res_idx] <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A new result is loaded only on leaving the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit step");

  // A steal happens only with every voice busy
  a_steal_all_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && res_grant && res_stolen) |-> (&busy))
    else $error("steal with an idle voice present");

  // Memory slots are issued only while scanning
  a_issue_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == ST_SCAN))
    else $error("memory slot issued outside scan");

  // A refused request reports index zero and no steal
  a_refuse_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.granted) |-> (result.voice_index == '0 && !result.was_stolen))
    else $error("refused request carries index or steal flag");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the voice steal allocator.
// Predicts grants, steals and refusals from a shadow copy of the voice pool.
// Depends on vsa_pkg and voice_steal_allocator.
module testbench;
  import vsa_pkg::*;

  localparam int VOICES = 16;
  localparam int RANDOM_ITEMS = 1400;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   in_item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t out_res;

  // Shadow of the voice pool and listener
  logic                    busy_m [VOICES];
  logic                    rel_m  [VOICES];
  logic signed [POS_W-1:0] vx_m [VOICES];
  logic signed [POS_W-1:0] vy_m [VOICES];
  logic signed [POS_W-1:0] vz_m [VOICES];
  logic signed [POS_W-1:0] lis_x = '0;
  logic signed [POS_W-1:0] lis_y = '0;
  logic signed [POS_W-1:0] lis_z = '0;

  item_t   pend_q [$];
  result_t grant_q [$];
  result_t want;
  logic    sent_ok = 1'b0;
  int      err_cnt = 0;
  int      cycle_cnt = 0;
  int      burst_left = 1;
  int      gap_left = 0;
  int      rx_left = 0;
  logic    rx_stall_now = 1'b0;

  voice_steal_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (in_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (out_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Squared distance from the listener, exact
  function automatic longint dist_sq(logic signed [POS_W-1:0] x,
                                     logic signed [POS_W-1:0] y,
                                     logic signed [POS_W-1:0] z);
    longint dx, dy, dz;
    dx = x;
    dy = y;
    dz = z;
    dx = dx - lis_x;
    dy = dy - lis_y;
    dz = dz - lis_z;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Append one item to the pending queue
  function automatic void queue_item(item_t it);
    pend_q = {pend_q, it};
  endfunction

  // Apply one accepted item to the shadow pool; queue the result of each play
  function automatic void alloc_voice(item_t it);
    result_t res;
    int      pick, sel;
    logic    hit;
    longint  best, d;
    res = '0;
    pick = 0;
    hit = 1'b0;
    case (it.cmd)
      CMD_RELEASE: begin
        if (it.release_voice < VOICES) busy_m[it.release_voice] = 1'b0;
      end
      CMD_LISTENER: begin
        lis_x = it.pos_x;
        lis_y = it.pos_y;
        lis_z = it.pos_z;
      end
      CMD_PLAY: begin
        // lowest idle voice first
        for (int i = 0; i < VOICES; i++) begin
          if (!hit && !busy_m[i]) begin
            pick = i;
            hit = 1'b1;
          end
        end
        // pool full: find farthest stealable voice, ties to the lower index
        if (!hit) begin
          sel = 0;
          best = dist_sq(vx_m[0], vy_m[0], vz_m[0]);
          for (int i = 1; i < VOICES; i++) begin
            d = dist_sq(vx_m[i], vy_m[i], vz_m[i]);
            if (d > best && !rel_m[i]) begin
              sel = i;
              best = d;
            end
          end
          if (best > dist_sq(it.pos_x, it.pos_y, it.pos_z) && !rel_m[sel]) begin
            pick = sel;
            hit = 1'b1;
            res.was_stolen = 1'b1;
          end
        end
        if (hit) begin
          busy_m[pick] = 1'b1;
          rel_m[pick] = it.is_relative;
          vx_m[pick] = it.pos_x;
          vy_m[pick] = it.pos_y;
          vz_m[pick] = it.pos_z;
          res.granted = 1'b1;
          res.voice_index = pick[VIDX_W-1:0];
        end
        grant_q = {grant_q, res};
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk_item(logic [CMD_W-1:0] c, int x, int y, int z,
                                    logic rel, int rv);
    item_t it;
    it.cmd = c;
    it.pos_x = x[POS_W-1:0];
    it.pos_y = y[POS_W-1:0];
    it.pos_z = z[POS_W-1:0];
    it.is_relative = rel;
    it.release_voice = rv[RV_W-1:0];
    return it;
  endfunction

  // Mix clustered, extreme and full-range coordinates so ties happen
  function automatic logic signed [POS_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return POS_W'($urandom_range(0, 6) - 3);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // Sender: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !sent_ok) begin
      // hold current item
    end else if (gap_left > 0) begin
      gap_left--;
      item_valid <= 1'b0;
    end else if (pend_q.size() != 0) begin
      in_item <= pend_q.pop_front();
      item_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        burst_left = 150;
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap_left = $urandom_range(0, 12);
      end
    end else begin
      item_valid <= 1'b0;
    end
  end

  // Receiver: alternate stall and open runs, with long open stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_stall_now = !rx_stall_now;
      if (rx_stall_now) rx_left = $urandom_range(1, 14);
      else if ($urandom_range(0, 7) == 0) rx_left = 300;
      else rx_left = $urandom_range(1, 10);
    end
    rx_left--;
    result_stall <= rx_stall_now;
  end

  // Check results against the oldest expectation, then predict new items
  always @(posedge clk) begin
    cycle_cnt++;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (grant_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_res);
        end else begin
          want = grant_q.pop_front();
          if (out_res.granted !== want.granted) begin
            err_cnt++;
            $display("%0t: granted expected %0d got %0d", $time, want.granted,
                     out_res.granted);
          end
          if (out_res.voice_index !== want.voice_index) begin
            err_cnt++;
            $display("%0t: voice_index expected %0d got %0d", $time,
                     want.voice_index, out_res.voice_index);
          end
          if (out_res.was_stolen !== want.was_stolen) begin
            err_cnt++;
            $display("%0t: was_stolen expected %0d got %0d", $time,
                     want.was_stolen, out_res.was_stolen);
          end
        end
      end
      if (item_valid && !item_stall) alloc_voice(in_item);
    end
    sent_ok <= item_valid && !item_stall && !rst;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int   n, r, d;
    item_t it;
    for (int i = 0; i < VOICES; i++) busy_m[i] = 1'b0;

    // Directed: fill the pool with a relative farthest voice at slot 0
    queue_item(mk_item(CMD_PLAY, -32768, -32768, -32768, 1'b1, 15));
    for (int k = 1; k < VOICES; k++) begin
      d = 1000 * ((k + 1) / 2);
      queue_item(mk_item(CMD_PLAY, (k % 2) ? d : -d, 0, 0, k == 5, 0));
    end
    // farthest voice is relative: refuse
    queue_item(mk_item(CMD_PLAY, 0, 0, 0, 1'b0, 0));
    // free voice 0 twice, the second time it is already idle
    queue_item(mk_item(CMD_RELEASE, 0, 0, 0, 1'b0, 0));
    queue_item(mk_item(CMD_RELEASE, 0, 0, 0, 1'b0, 0));
    queue_item(mk_item(CMD_PLAY, 32767, 32767, 32767, 1'b0, 0));
    // move listener to the far corner, then steal
    queue_item(mk_item(CMD_LISTENER, -32768, -32768, -32768, 1'b0, 0));
    queue_item(mk_item(CMD_PLAY, 32767, -32768, 0, 1'b0, 0));
    queue_item(mk_item(CMD_PLAY, -32768, -32768, -32768, 1'b0, 0));
    // equal distance to the farthest voice: refuse
    queue_item(mk_item(CMD_LISTENER, 0, 0, 0, 1'b1, 9));
    queue_item(mk_item(CMD_PLAY, -32768, -32768, -32768, 1'b0, 0));
    queue_item(mk_item(CMD_UNUSED, 12345, -1, 32767, 1'b1, 7));

    // Random: plays dominate so the pool stays full most of the time
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      it.pos_x = rand_coord();
      it.pos_y = rand_coord();
      it.pos_z = rand_coord();
      it.is_relative = ($urandom_range(0, 4) == 0);
      it.release_voice = RV_W'($urandom);
      if (r < 52) it.cmd = CMD_PLAY;
      else if (r < 78) it.cmd = CMD_RELEASE;
      else if (r < 93) it.cmd = CMD_LISTENER;
      else it.cmd = CMD_UNUSED;
      queue_item(it);
      n++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Drain, then let the block settle
    while (pend_q.size() != 0 || item_valid || grant_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (grant_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
